[rtl/core/apa_ser_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package apa_ser_pkg;

    localparam int PIXEL_COUNT    = 8;
    localparam int PIX_IDX_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int BITS_PER_PIXEL = 32;
    localparam int PIXEL_BITS     = PIXEL_COUNT * BITS_PER_PIXEL;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // longest frame: both zero runs at their maximum plus all pixel bits
    localparam int MAX_FRAME = 2 * ((1 << CFG_W) - 1) + PIXEL_BITS;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SHOW  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ZERO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ZERO   = 1'd1;

    localparam logic [CFG_W-1:0] START_ZERO_RESET = 6'd32;
    localparam logic [CFG_W-1:0] END_ZERO_RESET   = 6'd36;

    // top three bits of the brightness byte are always set
    localparam logic [2:0] LED_FRAME_MARK = 3'b111;

    typedef struct packed {
        logic [4:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic       wr_en;
        logic       clear;
        logic [2:0] idx;
        pixel_t     data;
    } store_ctrl_t;

    typedef struct packed {
        logic data_bit;
        logic clock_pulse;
        logic busy;
        logic done;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/apa_ser_pixel_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module apa_ser_pixel_store (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire apa_ser_pkg::store_ctrl_t           ctrl,
    input  wire logic [apa_ser_pkg::PIX_IDX_W-1:0]  rd_idx,
    output apa_ser_pkg::pixel_t                     rd_data
);

    apa_ser_pkg::pixel_t store_reg [apa_ser_pkg::PIXEL_COUNT];

    // out-of-range set items match no entry and fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apa_ser_pkg::PIXEL_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < apa_ser_pkg::PIXEL_COUNT; i++)
            begin
                if (ctrl.clear)
                begin
                    store_reg[i] <= '0;
                end
                else if (ctrl.wr_en && (int'(ctrl.idx) == i))
                begin
                    store_reg[i] <= ctrl.data;
                end
            end
        end
    end

    assign rd_data = store_reg[rd_idx];

endmodule

`default_nettype wire

[rtl/core/apa_ser_frame_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module apa_ser_frame_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               take,
    input  wire logic [1:0]                         command,
    input  wire logic [2:0]                         pixel,
    input  wire logic [4:0]                         brightness_level,
    input  wire logic [7:0]                         red,
    input  wire logic [7:0]                         green,
    input  wire logic [7:0]                         blue,
    input  wire logic [apa_ser_pkg::CFG_W-1:0]      start_cfg,
    input  wire logic [apa_ser_pkg::CFG_W-1:0]      end_cfg,
    input  wire apa_ser_pkg::pixel_t                rd_data,
    output logic [apa_ser_pkg::PIX_IDX_W-1:0]       rd_idx,
    output apa_ser_pkg::store_ctrl_t                store_ctrl,
    output apa_ser_pkg::result_t                    result
);

    logic                                sending_reg;
    logic                                sending_next;
    logic [apa_ser_pkg::POS_W-1:0]       bit_pos_reg;
    logic [apa_ser_pkg::POS_W-1:0]       bit_pos_next;
    logic [apa_ser_pkg::CFG_W-1:0]       start_len_reg;
    logic [apa_ser_pkg::CFG_W-1:0]       start_len_next;
    logic [apa_ser_pkg::POS_W-1:0]       total_len_reg;
    logic [apa_ser_pkg::POS_W-1:0]       total_len_next;

    logic [apa_ser_pkg::POS_W-1:0]       q;
    logic [apa_ser_pkg::POS_W-1:0]       pos_inc;
    logic                                in_pixels;
    logic                                last_bit;
    logic [7:0]                          px_byte;
    logic                                frame_bit;

    // offset into the pixel section
    assign q         = bit_pos_reg - apa_ser_pkg::POS_W'(start_len_reg);
    assign in_pixels = (bit_pos_reg >= apa_ser_pkg::POS_W'(start_len_reg))
                       && (q < apa_ser_pkg::POS_W'(apa_ser_pkg::PIXEL_BITS));
    assign rd_idx    = q[apa_ser_pkg::PIX_IDX_W+4:5];
    assign pos_inc   = bit_pos_reg + 1'b1;
    assign last_bit  = (pos_inc >= total_len_reg);

    always_comb
    begin
        case (q[4:3])
            2'd0:    px_byte = {apa_ser_pkg::LED_FRAME_MARK, rd_data.level};
            2'd1:    px_byte = rd_data.red;
            2'd2:    px_byte = rd_data.green;
            default: px_byte = rd_data.blue;
        endcase
    end

    // msb first: bit 7 - q[2:0]
    assign frame_bit = in_pixels & px_byte[~q[2:0]];

    always_comb
    begin
        sending_next      = sending_reg;
        bit_pos_next      = bit_pos_reg;
        start_len_next    = start_len_reg;
        total_len_next    = total_len_reg;
        result            = '0;
        store_ctrl        = '0;
        store_ctrl.idx    = pixel;
        store_ctrl.data   = '{level: brightness_level, red: red, green: green, blue: blue};

        if (command == apa_ser_pkg::CMD_TICK)
        begin
            if (sending_reg)
            begin
                result.data_bit    = frame_bit;
                result.clock_pulse = 1'b1;
                if (last_bit)
                begin
                    sending_next = 1'b0;
                    bit_pos_next = '0;
                    result.done  = 1'b1;
                end
                else
                begin
                    bit_pos_next = pos_inc;
                    result.busy  = 1'b1;
                end
            end
        end
        else if (sending_reg)
        begin
            result.busy = 1'b1;
        end
        else
        begin
            unique case (command)
                apa_ser_pkg::CMD_SET:
                begin
                    store_ctrl.wr_en = take;
                end
                apa_ser_pkg::CMD_CLEAR:
                begin
                    store_ctrl.clear = take;
                end
                apa_ser_pkg::CMD_SHOW:
                begin
                    start_len_next = start_cfg;
                    total_len_next = apa_ser_pkg::POS_W'(start_cfg)
                                     + apa_ser_pkg::POS_W'(apa_ser_pkg::PIXEL_BITS)
                                     + apa_ser_pkg::POS_W'(end_cfg);
                    bit_pos_next   = '0;
                    sending_next   = 1'b1;
                    result.busy    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg   <= 1'b0;
            bit_pos_reg   <= '0;
            start_len_reg <= '0;
            total_len_reg <= '0;
        end
        else if (take)
        begin
            sending_reg   <= sending_next;
            bit_pos_reg   <= bit_pos_next;
            start_len_reg <= start_len_next;
            total_len_reg <= total_len_next;
        end
    end

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg |-> (bit_pos_reg < total_len_reg))
        else $error("bit position ran past frame length");

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (bit_pos_reg == '0))
        else $error("bit position not parked while idle");

    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.done) |=> !sending_reg)
        else $error("frame still running after last bit");

endmodule

`default_nettype wire

[rtl/core/apa102_frame_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+----------------------------------------------
// command   | cmd_valid / cmd_stall  | command, pixel, brightness_level, red, green,
//           |                        | blue
// result    | res_valid / res_stall  | data_bit, clock_pulse, busy_res, frame_done
// config    | cfg_write              | cfg_index, cfg_data
//
// one item per cycle while cmd_stall is low: the result of each transfer lands in the
// output register on the next edge
// reset clears the pixel store to level zero and black, idles the frame engine and
// loads the zero-run registers with 32 and 36
// cmd_stall rises only while a result sits in the output register and res_stall is
// high; a result taken in the same cycle frees the slot for the next transfer

module apa102_frame_serializer (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  cmd_valid,
    output logic                                       cmd_stall,
    input  wire logic [1:0]                            command,
    input  wire logic [2:0]                            pixel,
    input  wire logic [4:0]                            brightness_level,
    input  wire logic [7:0]                            red,
    input  wire logic [7:0]                            green,
    input  wire logic [7:0]                            blue,

    output logic                                       res_valid,
    input  wire logic                                  res_stall,
    output logic                                       data_bit,
    output logic                                       clock_pulse,
    output logic                                       busy_res,
    output logic                                       frame_done,

    input  wire logic                                  cfg_write,
    input  wire logic [apa_ser_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [apa_ser_pkg::CFG_W-1:0]         cfg_data
);

    // zero-run lengths, copied into the frame engine when a show is taken
    logic [apa_ser_pkg::CFG_W-1:0]           start_cfg_reg;
    logic [apa_ser_pkg::CFG_W-1:0]           end_cfg_reg;

    // output register
    logic                                    res_valid_reg;
    apa_ser_pkg::result_t                    res_reg;

    logic                                    take;
    apa_ser_pkg::store_ctrl_t                store_ctrl;
    logic [apa_ser_pkg::PIX_IDX_W-1:0]       rd_idx;
    apa_ser_pkg::pixel_t                     rd_data;
    apa_ser_pkg::result_t                    result;

    // the slot is free when empty or drained in this cycle
    assign cmd_stall = res_valid_reg & res_stall;
    assign take      = cmd_valid & ~cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cfg_reg <= apa_ser_pkg::START_ZERO_RESET;
            end_cfg_reg   <= apa_ser_pkg::END_ZERO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                apa_ser_pkg::CFG_START_ZERO: start_cfg_reg <= cfg_data;
                apa_ser_pkg::CFG_END_ZERO:   end_cfg_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    apa_ser_pixel_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    apa_ser_frame_ctrl u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .command          (command),
        .pixel            (pixel),
        .brightness_level (brightness_level),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .start_cfg        (start_cfg_reg),
        .end_cfg          (end_cfg_reg),
        .rd_data          (rd_data),
        .rd_idx           (rd_idx),
        .store_ctrl       (store_ctrl),
        .result           (result)
    );

    // control bit of the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= result;
        end
    end

    assign res_valid   = res_valid_reg;
    assign data_bit    = res_reg.data_bit;
    assign clock_pulse = res_reg.clock_pulse;
    assign busy_res    = res_reg.busy;
    assign frame_done  = res_reg.done;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid)
        else $error("command stalled with empty output register");

    a_transfer_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> res_valid)
        else $error("accepted command produced no result");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_done) |-> (clock_pulse && !busy_res))
        else $error("frame end result malformed");

endmodule

`default_nettype wire
